// ===== hdl/ptc_pkg.sv =====
// shared types and constants for the pressure/temperature compensation block
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_STAGES  = 9;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SENSITIVITY      = 3'd0,
    REG_OFFSET           = 3'd1,
    REG_SENSITIVITY_TEMP = 3'd2,
    REG_OFFSET_TEMP      = 3'd3,
    REG_REFERENCE_TEMP   = 3'd4,
    REG_TEMP_SLOPE       = 3'd5,
    REG_RANGE_MODEL      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] pressure_value;
  } out_word_t;

endpackage

// ===== hdl/pressure_temp_compensation.sv =====
// second-order pressure/temperature compensation pipeline
`timescale 1ns / 1ps

// Usage:
//  - input channel (in_valid/in_ready/in_data) takes one word holding a raw
//    pressure and a raw temperature conversion
//  - output channel (out_valid/out_ready/out_data) returns one word per input
//    word, in order: temperature in 0.01 degC and compensated pressure
//  - six calibration words and the range model bit are written through the
//    cfg_wr_en/cfg_index/cfg_data port; the user must do so only while no
//    word is in flight, which the block does not enforce; writes to an index
//    past the range model bit are dropped
//  - nine register stages, from stage 1 up to the stage 9 output register
//  - one word per cycle sustained while out_ready is high: each stage has its
//    own valid bit, loads when empty or its successor moves; bubbles close up
//  - when the receiver holds out_ready low the last stage keeps its word and
//    the stall backs up stage by stage; in_ready falls only once every stage
//    is full
//  - synchronous reset empties the pipeline and clears all calibration
//    registers to zero
//  - the long product raw_pressure * sensitivity is split into two partial
//    products in stage 7 and summed in stage 8
module pressure_temp_compensation (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ptc_pkg::in_word_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ptc_pkg::out_word_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ptc_pkg::*;

  // signed divide by 2**k, truncating toward zero
  function automatic logic signed [63:0] div_pow2(input logic signed [63:0] v,
                                                  input logic [5:0] k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

  // calibration registers
  logic [15:0] sensitivity_coeff;
  logic [15:0] offset_coeff;
  logic [15:0] sensitivity_temp_coeff;
  logic [15:0] offset_temp_coeff;
  logic [15:0] reference_temp_coeff;
  logic [15:0] temp_slope_coeff;
  logic        range_model;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_coeff      <= '0;
      offset_coeff           <= '0;
      sensitivity_temp_coeff <= '0;
      offset_temp_coeff      <= '0;
      reference_temp_coeff   <= '0;
      temp_slope_coeff       <= '0;
      range_model            <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENSITIVITY:      sensitivity_coeff      <= cfg_data;
        REG_OFFSET:           offset_coeff           <= cfg_data;
        REG_SENSITIVITY_TEMP: sensitivity_temp_coeff <= cfg_data;
        REG_OFFSET_TEMP:      offset_temp_coeff      <= cfg_data;
        REG_REFERENCE_TEMP:   reference_temp_coeff   <= cfg_data;
        REG_TEMP_SLOPE:       temp_slope_coeff       <= cfg_data;
        REG_RANGE_MODEL:      range_model            <= cfg_data[0];
        default:              ;
      endcase
    end
  end

  // stage valid bits and per-stage load enables
  logic [NUM_STAGES:1] stage_valid;
  logic [NUM_STAGES:1] stage_en;

  always_comb begin
    stage_en[NUM_STAGES] = !stage_valid[NUM_STAGES] || out_ready;
    for (int i = NUM_STAGES - 1; i >= 1; i--) begin
      stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[1]) stage_valid[1] <= in_valid;
      for (int i = 2; i <= NUM_STAGES; i++) begin
        if (stage_en[i]) stage_valid[i] <= stage_valid[i-1];
      end
    end
  end

  assign in_ready  = stage_en[1];
  assign out_valid = stage_valid[NUM_STAGES];

  // stage 1: temperature difference against the reference
  logic        [23:0] s1_d1;
  logic signed [24:0] s1_dt;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s1_d1 <= in_data.raw_pressure;
      s1_dt <= $signed({1'b0, in_data.raw_temperature})
             - $signed({1'b0, reference_temp_coeff, 8'h00});
    end
  end

  // stage 2: products of the temperature difference
  logic        [23:0] s2_d1;
  logic signed [41:0] s2_sens_prod;
  logic signed [41:0] s2_off_prod;
  logic signed [41:0] s2_temp_prod;
  logic        [47:0] s2_dt_sq;
  logic signed [49:0] dt_sq_full;

  assign dt_sq_full = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s2_d1        <= s1_d1;
      s2_sens_prod <= $signed({1'b0, sensitivity_temp_coeff}) * s1_dt;
      s2_off_prod  <= $signed({1'b0, offset_temp_coeff}) * s1_dt;
      s2_temp_prod <= $signed({1'b0, temp_slope_coeff}) * s1_dt;
      s2_dt_sq     <= dt_sq_full[47:0];
    end
  end

  // stage 3: first-order sensitivity, offset, temperature; temperature term
  logic signed [63:0] sens_scaled;
  logic signed [63:0] off_scaled;
  logic signed [63:0] temp_scaled;
  logic signed [37:0] sens_base;
  logic signed [37:0] off_base;
  logic signed [17:0] x_first;
  logic        [51:0] dt_sq_x11;
  logic        [49:0] dt_sq_x3;
  logic        [16:0] ti_next;

  assign sens_scaled = range_model ? div_pow2(64'(s2_sens_prod), 6'd7)
                                   : div_pow2(64'(s2_sens_prod), 6'd8);
  assign off_scaled  = range_model ? div_pow2(64'(s2_off_prod), 6'd6)
                                   : div_pow2(64'(s2_off_prod), 6'd7);
  assign temp_scaled = div_pow2(64'(s2_temp_prod), 6'd23);
  assign sens_base   = range_model ? $signed({6'b0, sensitivity_coeff, 16'b0})
                                   : $signed({7'b0, sensitivity_coeff, 15'b0});
  assign off_base    = range_model ? $signed({5'b0, offset_coeff, 17'b0})
                                   : $signed({6'b0, offset_coeff, 16'b0});
  assign x_first     = temp_scaled[17:0];
  assign dt_sq_x11   = 52'(s2_dt_sq) * 52'd11;
  assign dt_sq_x3    = 50'(s2_dt_sq) * 50'd3;

  always_comb begin
    if (range_model) begin
      ti_next = x_first[17] ? dt_sq_x11[51:35] : 17'd0;
    end else if (x_first[17]) begin
      ti_next = dt_sq_x3[49:33];
    end else begin
      ti_next = {5'b0, s2_dt_sq[47:36]};
    end
  end

  logic        [23:0] s3_d1;
  logic signed [37:0] s3_sens;
  logic signed [37:0] s3_off;
  logic signed [17:0] s3_x;
  logic        [16:0] s3_ti;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s3_d1   <= s2_d1;
      s3_sens <= sens_base + sens_scaled[37:0];
      s3_off  <= off_base + off_scaled[37:0];
      s3_x    <= x_first;
      s3_ti   <= ti_next;
    end
  end

  // stage 4: squares for the correction terms, final temperature
  logic signed [18:0] y_val;
  logic signed [35:0] x_sq_full;
  logic signed [37:0] y_sq_full;

  assign y_val     = 19'(s3_x) + 19'sd3500;
  assign x_sq_full = s3_x * s3_x;
  assign y_sq_full = y_val * y_val;

  logic        [23:0] s4_d1;
  logic signed [37:0] s4_sens;
  logic signed [37:0] s4_off;
  logic        [33:0] s4_xx;
  logic        [31:0] s4_yy;
  logic               s4_low;
  logic               s4_very_low;
  logic signed [19:0] s4_temp;

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s4_d1       <= s3_d1;
      s4_sens     <= s3_sens;
      s4_off      <= s3_off;
      s4_xx       <= x_sq_full[33:0];
      s4_yy       <= y_sq_full[31:0];
      s4_low      <= s3_x[17];
      s4_very_low <= s3_x < -18'sd3500;
      s4_temp     <= 20'sd2000 + 20'(s3_x) - $signed({3'b0, s3_ti});
    end
  end

  // stage 5: offset and sensitivity corrections, modulo 2**32
  logic [39:0] xx_x31;
  logic [39:0] xx_x63;
  logic [39:0] xx_x3;
  logic [39:0] xx_x5;
  logic [31:0] yy_x7;
  logic [31:0] offi_next;
  logic [31:0] sensi_next;

  assign xx_x31 = 40'(s4_xx) * 40'd31;
  assign xx_x63 = 40'(s4_xx) * 40'd63;
  assign xx_x3  = 40'(s4_xx) * 40'd3;
  assign xx_x5  = 40'(s4_xx) * 40'd5;
  assign yy_x7  = s4_yy * 32'd7;

  always_comb begin
    offi_next  = '0;
    sensi_next = '0;
    if (range_model) begin
      if (s4_low) begin
        offi_next  = xx_x31[34:3];
        sensi_next = xx_x63[36:5];
      end
    end else if (s4_low) begin
      offi_next  = xx_x3[32:1];
      sensi_next = xx_x5[34:3];
      if (s4_very_low) begin
        offi_next  = offi_next + yy_x7;
        sensi_next = sensi_next + {s4_yy[29:0], 2'b00};
      end
    end else begin
      offi_next = {2'b00, s4_xx[33:4]};
    end
  end

  logic        [23:0] s5_d1;
  logic signed [37:0] s5_sens;
  logic signed [37:0] s5_off;
  logic        [31:0] s5_offi;
  logic        [31:0] s5_sensi;
  logic signed [19:0] s5_temp;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s5_d1    <= s4_d1;
      s5_sens  <= s4_sens;
      s5_off   <= s4_off;
      s5_offi  <= offi_next;
      s5_sensi <= sensi_next;
      s5_temp  <= s4_temp;
    end
  end

  // stage 6: apply the corrections
  logic        [23:0] s6_d1;
  logic signed [37:0] s6_sens;
  logic signed [37:0] s6_off;
  logic signed [19:0] s6_temp;

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s6_d1   <= s5_d1;
      s6_sens <= s5_sens - 38'($signed(s5_sensi));
      s6_off  <= s5_off - 38'($signed(s5_offi));
      s6_temp <= s5_temp;
    end
  end

  // stage 7: raw pressure times sensitivity as two partial products
  logic        [42:0] s7_pp_lo;
  logic signed [43:0] s7_pp_hi;
  logic signed [37:0] s7_off;
  logic signed [19:0] s7_temp;

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s7_pp_lo <= 43'(s6_d1) * 43'(s6_sens[18:0]);
      s7_pp_hi <= $signed({1'b0, s6_d1}) * $signed(s6_sens[37:19]);
      s7_off   <= s6_off;
      s7_temp  <= s6_temp;
    end
  end

  // stage 8: sum partial products and scale down
  logic signed [63:0] full_prod;
  logic signed [63:0] prod_scaled;

  assign full_prod   = (64'(s7_pp_hi) <<< 19) + $signed({21'b0, s7_pp_lo});
  assign prod_scaled = div_pow2(full_prod, 6'd21);

  logic signed [42:0] s8_quot;
  logic signed [37:0] s8_off;
  logic signed [19:0] s8_temp;

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      s8_quot <= prod_scaled[42:0];
      s8_off  <= s7_off;
      s8_temp <= s7_temp;
    end
  end

  // stage 9: subtract offset, final scaling, output register
  logic signed [43:0] pres_diff;
  logic signed [63:0] pres_scaled;

  assign pres_diff   = 44'(s8_quot) - 44'(s8_off);
  assign pres_scaled = range_model ? div_pow2(64'(pres_diff), 6'd15)
                                   : div_pow2(64'(pres_diff), 6'd13);

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      out_data.temperature_centi <= 32'(s8_temp);
      out_data.pressure_value    <= pres_scaled[31:0];
    end
  end

endmodule

// ===== hdl/ptc_checker.sv =====
// port-level checker for the compensation pipeline, bound to the top level
`timescale 1ns / 1ps

module ptc_port_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input ptc_pkg::out_word_t   out_data
);
  import ptc_pkg::*;

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

  // a drained or moving output stage never blocks the input
  assert property (@(posedge clk) disable iff (rst)
                   (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output stage free");

  // a stalled output word holds
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed or dropped during stall");

  // with input blocked, the output must be both full and stalled
  assert property (@(posedge clk) disable iff (rst)
                   !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without an output stall");

endmodule

bind pressure_temp_compensation ptc_port_checker u_ptc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/ptc_checker.sv =====
// checker for the compensation block: predicts each word and compares results
`timescale 1ns / 1ps

module ptc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  ptc_pkg::in_word_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  ptc_pkg::out_word_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              errors,
  output int                              outstanding,
  output int                              checked,
  output int                              cold_words,
  output int                              very_cold_words,
  output int                              two_bar_words
);
  import ptc_pkg::*;

  localparam int MAX_REPORTS = 200;

  localparam longint PRES_DIV          = 64'sd2097152;
  localparam longint TEMP_DIV          = 64'sd8388608;
  localparam longint TI_COLD_2BAR_DIV  = 64'sd34359738368;
  localparam longint TI_COLD_30BAR_DIV = 64'sd8589934592;
  localparam longint TI_HOT_30BAR_DIV  = 64'sd137438953472;
  localparam longint TEMP_REF          = 64'sd2000;
  localparam longint TEMP_VERY_COLD    = -64'sd1500;

  // calibration as the block should hold it
  logic [15:0] sens_c, off_c, sens_t_c, off_t_c, ref_t_c, slope_c;
  logic        two_bar;

  out_word_t expected_q[$];

  function automatic longint wrap32(input longint v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // full compensation of one raw pair under the current calibration
  function automatic out_word_t compensate(input in_word_t w, output bit cold,
                                           output bit very_cold);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, sens, off, t, x, y, ti, offi, sensi, pres;
    out_word_t r;
    d1 = {40'd0, w.raw_pressure};
    d2 = {40'd0, w.raw_temperature};
    c1 = {48'd0, sens_c};
    c2 = {48'd0, off_c};
    c3 = {48'd0, sens_t_c};
    c4 = {48'd0, off_t_c};
    c5 = {48'd0, ref_t_c};
    c6 = {48'd0, slope_c};
    ti = 0;
    offi = 0;
    sensi = 0;
    dt = d2 - c5 * 256;
    if (two_bar) begin
      sens = c1 * 65536 + (c3 * dt) / 128;
      off  = c2 * 131072 + (c4 * dt) / 64;
    end else begin
      sens = c1 * 32768 + (c3 * dt) / 256;
      off  = c2 * 65536 + (c4 * dt) / 128;
    end
    t = TEMP_REF + (dt * c6) / TEMP_DIV;
    x = t - TEMP_REF;
    cold = (t < TEMP_REF);
    very_cold = 1'b0;
    if (two_bar) begin
      if (cold) begin
        ti    = wrap32((11 * dt * dt) / TI_COLD_2BAR_DIV);
        offi  = wrap32((31 * x * x) / 8);
        sensi = wrap32((63 * x * x) / 32);
      end
    end else if (cold) begin
      ti    = wrap32((3 * dt * dt) / TI_COLD_30BAR_DIV);
      offi  = wrap32((3 * x * x) / 2);
      sensi = wrap32((5 * x * x) / 8);
      if (t < TEMP_VERY_COLD) begin
        very_cold = 1'b1;
        y = t - TEMP_VERY_COLD;
        offi  = wrap32(offi + wrap32(7 * y * y));
        sensi = wrap32(sensi + wrap32(4 * y * y));
      end
    end else begin
      ti   = wrap32((2 * dt * dt) / TI_HOT_30BAR_DIV);
      offi = wrap32((x * x) / 16);
    end
    off  = off - offi;
    sens = sens - sensi;
    t    = t - ti;
    if (two_bar) pres = ((d1 * sens) / PRES_DIV - off) / 32768;
    else pres = ((d1 * sens) / PRES_DIV - off) / 8192;
    r.temperature_centi = t[31:0];
    r.pressure_value    = pres[31:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    bit        cold, very_cold;
    int        pushed, popped, bad;
    pushed = 0;
    popped = 0;
    bad = 0;
    if (rst) begin
      expected_q.delete();
      sens_c <= '0;
      off_c <= '0;
      sens_t_c <= '0;
      off_t_c <= '0;
      ref_t_c <= '0;
      slope_c <= '0;
      two_bar <= 1'b0;
      errors <= 0;
      outstanding <= 0;
      checked <= 0;
      cold_words <= 0;
      very_cold_words <= 0;
      two_bar_words <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SENSITIVITY:      sens_c <= cfg_data;
          REG_OFFSET:           off_c <= cfg_data;
          REG_SENSITIVITY_TEMP: sens_t_c <= cfg_data;
          REG_OFFSET_TEMP:      off_t_c <= cfg_data;
          REG_REFERENCE_TEMP:   ref_t_c <= cfg_data;
          REG_TEMP_SLOPE:       slope_c <= cfg_data;
          REG_RANGE_MODEL:      two_bar <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = compensate(in_data, cold, very_cold);
        expected_q.push_back(want);
        pushed = 1;
        cold_words <= cold_words + int'(cold);
        very_cold_words <= very_cold_words + int'(very_cold);
        two_bar_words <= two_bar_words + int'(two_bar);
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          bad++;
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected result word: expected none, got temperature %0d, pressure %0d",
                     $time, out_data.temperature_centi, out_data.pressure_value);
        end else begin
          want = expected_q.pop_front();
          popped = 1;
          if (out_data.temperature_centi !== want.temperature_centi) begin
            bad++;
            if (errors < MAX_REPORTS)
              $display("%0t: temperature_centi mismatch: expected %0d, got %0d",
                       $time, want.temperature_centi, out_data.temperature_centi);
          end
          if (out_data.pressure_value !== want.pressure_value) begin
            bad++;
            if (errors < MAX_REPORTS)
              $display("%0t: pressure_value mismatch: expected %0d, got %0d",
                       $time, want.pressure_value, out_data.pressure_value);
          end
        end
        checked <= checked + popped;
      end
      errors <= errors + bad;
      outstanding <= outstanding + pushed - popped;
    end
  end

endmodule

// ===== sim/tb_pressure_temp_compensation.sv =====
// testbench top for the pressure/temperature compensation block
`timescale 1ns / 1ps

module tb_pressure_temp_compensation;
  import ptc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int DRAIN_CYCLES  = NUM_STAGES + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 230;
  localparam int RANDOM_PHASES = 8;
  localparam int DIRECTED_NUM  = 10;

  // index past the last register: writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [15:0] sens;
    logic [15:0] off;
    logic [15:0] sens_t;
    logic [15:0] off_t;
    logic [15:0] ref_t;
    logic [15:0] slope;
    logic        two_bar;
  } cal_t;

  localparam int CAL_W = $bits(cal_t);

  // typical factory words for each range model
  localparam cal_t CAL_TYPICAL_30BAR = '{16'd34982, 16'd36352, 16'd20328, 16'd22354,
                                         16'd26646, 16'd26146, 1'b0};
  localparam cal_t CAL_TYPICAL_2BAR  = '{16'd46372, 16'd43981, 16'd29059, 16'd27842,
                                         16'd31553, 16'd28165, 1'b1};

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_data;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int errors, outstanding, checked, cold_words, very_cold_words, two_bar_words;
  int cycles;
  int cal_loads;

  // idling knobs shared between the stimulus and the receiver
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_rx = 1'b0;

  pressure_temp_compensation i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ptc_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .outstanding     (outstanding),
    .checked         (checked),
    .cold_words      (cold_words),
    .very_cold_words (very_cold_words),
    .two_bar_words   (two_bar_words)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles, %0d words still expected",
             $time, cycles, outstanding);
    $display("pressure_temp_compensation test failed");
    $finish;
  end

  // idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, a free-running mode, and one long hold-off on request
  initial begin : receiver
    int stall;
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_rx = 1'b0;
      end else if (rx_idle) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // raw temperature at a signed distance from the reference point, clamped to 24 bits
  function automatic logic [23:0] near_ref(input cal_t c, input longint delta);
    longint t;
    t = longint'({48'd0, c.ref_t}) * 256 + delta;
    if (t < 0) return '0;
    if (t > 64'sd16777215) return '1;
    return t[23:0];
  endfunction

  // random raw pair: half near the reference to split the cold/hot branches
  function automatic in_word_t rand_word(input cal_t c);
    in_word_t w;
    w.raw_pressure = 24'($urandom);
    if ($urandom_range(0, 15) == 0) w.raw_pressure = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 1)) w.raw_temperature = 24'($urandom);
    else w.raw_temperature = near_ref(c, longint'($urandom_range(0, 4194304)) - 2097152);
    return w;
  endfunction

  // offer one word; a leading gap drops valid first, otherwise valid stays up
  task automatic send_word(input in_word_t w);
    int gap;
    gap = tx_idle ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // wait for every expected result, then let the pipe settle
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all seven registers back to back, then a dropped write past the end
  task automatic load_cal(input cal_t c);
    cfg_reg_t             regs [7];
    logic [CFG_DATA_W-1:0] vals [7];
    regs = '{REG_SENSITIVITY, REG_OFFSET, REG_SENSITIVITY_TEMP, REG_OFFSET_TEMP,
             REG_REFERENCE_TEMP, REG_TEMP_SLOPE, REG_RANGE_MODEL};
    vals = '{c.sens, c.off, c.sens_t, c.off_t, c.ref_t, c.slope,
             {15'($urandom), c.two_bar}};
    cfg_wr_en <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_index <= REG_NONE;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cal_loads++;
  endtask

  // branch edges around the reference: very cold, the 20 degree step, hot, rails
  task automatic run_directed(input cal_t c);
    longint   deltas [DIRECTED_NUM];
    in_word_t w;
    deltas = '{-64'sd16777215, -64'sd1123500, -64'sd1122900, -64'sd321, -64'sd320,
               -64'sd1, 64'sd0, 64'sd1, 64'sd2000000, 64'sd16777215};
    load_cal(c);
    for (int i = 0; i < DIRECTED_NUM; i++) begin
      case (i % 3)
        0: w.raw_pressure = '0;
        1: w.raw_pressure = '1;
        default: w.raw_pressure = 24'($urandom);
      endcase
      w.raw_temperature = near_ref(c, deltas[i]);
      send_word(w);
    end
    stop_sending();
    wait_idle();
  endtask

  initial begin : stimulus
    cal_t c;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_SENSITIVITY;
    cfg_data <= '0;
    cal_loads = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // calibration still at its reset value
    send_word('{24'hFFFFFF, 24'hFFFFFF});
    send_word('{24'h000000, 24'h000000});
    stop_sending();
    wait_idle();

    run_directed(CAL_TYPICAL_30BAR);
    run_directed(CAL_TYPICAL_2BAR);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: c = CAL_TYPICAL_30BAR;
        1: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
        2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
        3: c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1};
        default: begin
          c = cal_t'(CAL_W'({$urandom, $urandom, $urandom, $urandom}));
          c.two_bar = p[0];
        end
      endcase
      // every third phase runs with no idling on either side
      tx_idle = (p % 3 != 2);
      rx_idle = (p % 3 != 2);
      load_cal(c);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // long receiver hold-off while words keep coming, so the pipe backs up
        if (p == 0 && i == 60) begin
          hold_rx = 1'b1;
          tx_idle = 1'b0;
        end
        if (p == 0 && i == 100) tx_idle = 1'b1;
        // sender pauses until the pipe has fully drained
        if (p == 1 && i == 115) begin
          stop_sending();
          wait_idle();
        end
        send_word(rand_word(c));
      end
      stop_sending();
      wait_idle();
    end

    $display("covered %0d words over %0d calibration sets, %0d through the 2-bar scaling",
             checked, cal_loads, two_bar_words);
    $display("low-temperature branch taken %0d times, very-low correction %0d times",
             cold_words, very_cold_words);
    if (errors == 0 && outstanding == 0) begin
      $display("pressure_temp_compensation test passed");
    end else begin
      $display("%0t: %0d mismatches, %0d words never returned", $time, errors, outstanding);
      $display("pressure_temp_compensation test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ptc_pkg.sv
hdl/pressure_temp_compensation.sv
hdl/ptc_checker.sv
sim/ptc_checker.sv
sim/tb_pressure_temp_compensation.sv
